// ===== hw/rtl/sfe_pkg.sv =====
// ----------------------------------------------------------------------------
// sfe_pkg
// shared constants, payload structs and control types of the slot allocator
// ----------------------------------------------------------------------------
package sfe_pkg;

   // sizing
   localparam int SLOT_CAPACITY = 256;
   localparam int KEY_BITS      = 16;
   localparam int POSITION_BITS = 24;

   localparam int SLOT_W      = (SLOT_CAPACITY > 1) ? $clog2(SLOT_CAPACITY) : 1;
   localparam int CNT_W       = $clog2(SLOT_CAPACITY + 1);
   localparam int KEY_W       = KEY_BITS;
   localparam int ENTRY_KEY_W = 2 * KEY_BITS;
   localparam int POS_W       = POSITION_BITS;
   localparam int EXT_W       = POSITION_BITS - 1;
   // 2*offset + extent - 2*camera needs three more bits than a position
   localparam int DIFF_W      = POSITION_BITS + 3;
   localparam int MAG_W       = POSITION_BITS + 2;
   localparam int SQ_W        = 2 * MAG_W;
   localparam int DIST_W      = SQ_W + 1;
   localparam int UPD_W       = 16;
   localparam int RSP_SLOT_W  = 8;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = POSITION_BITS;

   localparam logic [UPD_W-1:0] UPD_MAX = '1;

   // action codes
   localparam logic [1:0] ACT_REGISTER   = 2'd0;
   localparam logic [1:0] ACT_UNREGISTER = 2'd1;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_CAMERA_X    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CAMERA_Z    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TILE_EXTENT = 2'd2;

   typedef enum logic [2:0] {
      STS_INSERTED = 3'd0,
      STS_UPDATED  = 3'd1,
      STS_EVICTED  = 3'd2,
      STS_REMOVED  = 3'd3,
      STS_ABSENT   = 3'd4,
      STS_PRESENT  = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_SCAN,
      SEQ_DRAIN
   } seq_state_type;

   typedef struct packed {
      logic [1:0]              action;
      logic signed [KEY_W-1:0] key_x;
      logic signed [KEY_W-1:0] key_z;
      logic signed [POS_W-1:0] offset_x;
      logic signed [POS_W-1:0] offset_z;
   } req_type;

   typedef struct packed {
      status_type              status;
      logic [RSP_SLOT_W-1:0]   slot;
      logic                    evicted;
      logic signed [KEY_W-1:0] evicted_key_x;
      logic signed [KEY_W-1:0] evicted_key_z;
      logic [UPD_W-1:0]        upd_count;
   } rsp_type;

   // one table entry as read back
   typedef struct packed {
      logic                    valid;
      logic [ENTRY_KEY_W-1:0]  key;
      logic signed [POS_W-1:0] off_x;
      logic signed [POS_W-1:0] off_z;
      logic [UPD_W-1:0]        updates;
   } entry_type;

   // table write command
   typedef struct packed {
      logic                    set_entry;
      logic                    set_upd;
      logic                    clr_valid;
      logic [SLOT_W-1:0]       addr;
      logic [ENTRY_KEY_W-1:0]  key;
      logic signed [POS_W-1:0] off_x;
      logic signed [POS_W-1:0] off_z;
      logic [UPD_W-1:0]        updates;
   } tbl_wr_type;

   typedef struct packed {
      logic              pop;
      logic              push;
      logic              take_fresh;
      logic [SLOT_W-1:0] push_slot;
   } pool_ctl_type;

   typedef struct packed {
      logic [CNT_W-1:0]  free_count;
      logic [CNT_W-1:0]  next_fresh;
      logic [SLOT_W-1:0] top_slot;
   } pool_stat_type;

   // one scanned entry entering the distance pipeline
   typedef struct packed {
      logic                    live;
      logic                    cand;
      logic [SLOT_W-1:0]       slot;
      logic [ENTRY_KEY_W-1:0]  key;
      logic signed [POS_W-1:0] off_x;
      logic signed [POS_W-1:0] off_z;
   } dist_in_type;

   typedef struct packed {
      logic                   any;
      logic [SLOT_W-1:0]      slot;
      logic [ENTRY_KEY_W-1:0] key;
   } best_type;

endpackage

// ===== hw/rtl/sfe_table.sv =====
// ----------------------------------------------------------------------------
// sfe_table
// entry storage: valid flags in flops, key, offset and count in memories
// ----------------------------------------------------------------------------
module sfe_table
   import sfe_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [SLOT_W-1:0] rd_addr,
   input  tbl_wr_type        wr,
   output entry_type         rd_data
);

   logic [SLOT_CAPACITY-1:0] valid_ff;
   logic [SLOT_CAPACITY-1:0] valid_in;
   logic                     rd_valid_ff;

   logic [ENTRY_KEY_W-1:0] key_mem [SLOT_CAPACITY];
   logic [2*POS_W-1:0]     off_mem [SLOT_CAPACITY];
   logic [UPD_W-1:0]       upd_mem [SLOT_CAPACITY];

   logic [ENTRY_KEY_W-1:0] rd_key_ff;
   logic [2*POS_W-1:0]     rd_off_ff;
   logic [UPD_W-1:0]       rd_upd_ff;

   always_comb begin
      valid_in = valid_ff;
      if (wr.set_entry) begin
         valid_in[wr.addr] = 1'b1;
      end
      if (wr.clr_valid) begin
         valid_in[wr.addr] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr.set_entry) begin
         key_mem[wr.addr] <= wr.key;
         off_mem[wr.addr] <= {wr.off_z, wr.off_x};
      end
      if (wr.set_upd) begin
         upd_mem[wr.addr] <= wr.updates;
      end
   end

   always_ff @(posedge clock) begin
      rd_key_ff <= key_mem[rd_addr];
      rd_off_ff <= off_mem[rd_addr];
      rd_upd_ff <= upd_mem[rd_addr];
   end

   assign rd_data.valid   = rd_valid_ff;
   assign rd_data.key     = rd_key_ff;
   assign rd_data.off_x   = signed'(rd_off_ff[POS_W-1:0]);
   assign rd_data.off_z   = signed'(rd_off_ff[2*POS_W-1:POS_W]);
   assign rd_data.updates = rd_upd_ff;

endmodule

// ===== hw/rtl/sfe_slot_pool.sv =====
// ----------------------------------------------------------------------------
// sfe_slot_pool
// lifo stack of freed slots plus the never-used slot counter
// ----------------------------------------------------------------------------
module sfe_slot_pool
   import sfe_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  pool_ctl_type  ctl,
   output pool_stat_type stat
);

   logic [SLOT_W-1:0] stack_mem [SLOT_CAPACITY];
   logic [CNT_W-1:0]  free_count_ff, free_count_in;
   logic [CNT_W-1:0]  next_fresh_ff, next_fresh_in;
   logic [SLOT_W-1:0] top_ff;
   logic [CNT_W-1:0]  top_idx;
   logic              push_ok;

   assign top_idx = free_count_ff - CNT_W'(1);
   assign push_ok = ctl.push && (free_count_ff < CNT_W'(SLOT_CAPACITY));

   always_comb begin
      free_count_in = free_count_ff;
      next_fresh_in = next_fresh_ff;
      if (ctl.pop) begin
         free_count_in = free_count_ff - CNT_W'(1);
      end else if (push_ok) begin
         free_count_in = free_count_ff + CNT_W'(1);
      end
      if (ctl.take_fresh) begin
         next_fresh_in = next_fresh_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_count_ff <= '0;
         next_fresh_ff <= '0;
      end else begin
         free_count_ff <= free_count_in;
         next_fresh_ff <= next_fresh_in;
      end
   end

   // top of stack, re-read every cycle
   always_ff @(posedge clock) begin
      if (push_ok) begin
         stack_mem[free_count_ff[SLOT_W-1:0]] <= ctl.push_slot;
      end
      top_ff <= stack_mem[top_idx[SLOT_W-1:0]];
   end

   assign stat.free_count = free_count_ff;
   assign stat.next_fresh = next_fresh_ff;
   assign stat.top_slot   = top_ff;

endmodule

// ===== hw/rtl/sfe_dist_unit.sv =====
// ----------------------------------------------------------------------------
// sfe_dist_unit
// pipelined squared distance to camera and running farthest-entry tracker
// ----------------------------------------------------------------------------
module sfe_dist_unit
   import sfe_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    clear,
   input  dist_in_type             din,
   input  logic signed [POS_W-1:0] cam_x,
   input  logic signed [POS_W-1:0] cam_z,
   input  logic [EXT_W-1:0]        extent,
   output logic                    busy,
   output best_type                best
);

   // stage: magnitudes
   logic signed [DIFF_W-1:0] dx, dz;
   logic [DIFF_W-1:0]        abs_x, abs_z;
   logic [MAG_W-1:0]         mag_x_ff, mag_z_ff;
   logic                     live2_ff, cand2_ff;
   logic [SLOT_W-1:0]        slot2_ff;
   logic [ENTRY_KEY_W-1:0]   key2_ff;

   // stage: squares
   logic [SQ_W-1:0]        sq_x_ff, sq_z_ff;
   logic                   live3_ff, cand3_ff;
   logic [SLOT_W-1:0]      slot3_ff;
   logic [ENTRY_KEY_W-1:0] key3_ff;

   // tracker
   logic [DIST_W-1:0] cur_dist;
   logic [DIST_W-1:0] best_dist_ff;
   logic              take;
   best_type          best_ff;

   // centre doubled, in 2^-9 units
   assign dx = {{2{din.off_x[POS_W-1]}}, din.off_x, 1'b0}
             + {{(DIFF_W-EXT_W){1'b0}}, extent}
             - {{2{cam_x[POS_W-1]}}, cam_x, 1'b0};
   assign dz = {{2{din.off_z[POS_W-1]}}, din.off_z, 1'b0}
             + {{(DIFF_W-EXT_W){1'b0}}, extent}
             - {{2{cam_z[POS_W-1]}}, cam_z, 1'b0};
   assign abs_x = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
   assign abs_z = dz[DIFF_W-1] ? DIFF_W'(-dz) : DIFF_W'(dz);

   always_ff @(posedge clock) begin
      mag_x_ff <= abs_x[MAG_W-1:0];
      mag_z_ff <= abs_z[MAG_W-1:0];
      cand2_ff <= din.cand;
      slot2_ff <= din.slot;
      key2_ff  <= din.key;
      sq_x_ff  <= mag_x_ff * mag_x_ff;
      sq_z_ff  <= mag_z_ff * mag_z_ff;
      cand3_ff <= cand2_ff;
      slot3_ff <= slot2_ff;
      key3_ff  <= key2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live2_ff <= 1'b0;
         live3_ff <= 1'b0;
      end else begin
         live2_ff <= din.live;
         live3_ff <= live2_ff;
      end
   end

   assign cur_dist = {1'b0, sq_x_ff} + {1'b0, sq_z_ff};
   // strict greater keeps the lowest slot on ties
   assign take = live3_ff && cand3_ff && (!best_ff.any || (cur_dist > best_dist_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff.any <= 1'b0;
      end else if (clear) begin
         best_ff.any <= 1'b0;
      end else if (take) begin
         best_ff.any <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         best_dist_ff  <= cur_dist;
         best_ff.slot  <= slot3_ff;
         best_ff.key   <= key3_ff;
      end
   end

   assign busy = live2_ff || live3_ff;
   assign best = best_ff;

endmodule

// ===== hw/rtl/slot_allocator_farthest_evict_unit.sv =====
// ----------------------------------------------------------------------------
// slot_allocator_farthest_evict_unit
// keyed slot table with farthest-from-camera eviction
// ----------------------------------------------------------------------------
// Each request transaction (register, unregister or query of a tile key) is
// handled by one full pass over the table: slots 0 to SLOT_CAPACITY-1 are read
// one per cycle from the entry memories, and every read entry is checked for a
// key match and fed to a shared distance pipeline that squares the offset of
// its tile centre from the camera and keeps the farthest one (lowest slot on
// ties). A request is answered only after its full scan and after the read and
// distance pipeline has drained; the single read port of the entry memories
// is why the scan reads one slot at a time. req_ready is high only while the
// sequencer is idle. A finished response sits in an output register, so the
// next request may be accepted and scanned while the response waits on
// rsp_ready; the following commit holds until that response is taken. New
// keys take the most recently freed slot, then the next never-used slot, and
// only with a full table evict the farthest entry. Camera and tile extent
// registers are written through the csr port; the user must write them only
// while no request is in flight, the block does not enforce this; index 3 is ignored.
// ----------------------------------------------------------------------------
module slot_allocator_farthest_evict_unit
   import sfe_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   // response channel
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   // configuration write port
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // sequencer
   seq_state_type     state_ff, state_in;
   logic [SLOT_W-1:0] addr_ff, addr_in;
   logic              issue;
   logic              start;
   logic              commit;
   logic              last_addr;

   // captured request
   req_type req_ff;

   // configuration registers
   logic signed [POS_W-1:0] cam_x_ff, cam_z_ff;
   logic [EXT_W-1:0]        extent_ff;

   // lookup stage, aligned with the table read data
   logic              s1_live_ff;
   logic [SLOT_W-1:0] s1_slot_ff;
   entry_type         rd_entry;
   logic              key_match;

   logic              hit_ff, hit_in;
   logic [SLOT_W-1:0] found_ff, found_in;
   logic [UPD_W-1:0]  found_cnt_ff, found_cnt_in;

   // sub-unit links
   tbl_wr_type    tbl_wr;
   pool_ctl_type  pool_ctl;
   pool_stat_type pool_stat;
   dist_in_type   dist_in;
   best_type      best;
   logic          dist_busy;

   // response register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   // ------------------------------------------------------------------
   // sub-units
   // ------------------------------------------------------------------
   sfe_table u_table (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (addr_ff),
      .wr      (tbl_wr),
      .rd_data (rd_entry)
   );

   sfe_slot_pool u_pool (
      .clock (clock),
      .reset (reset),
      .ctl   (pool_ctl),
      .stat  (pool_stat)
   );

   assign dist_in.live  = s1_live_ff;
   assign dist_in.cand  = rd_entry.valid;
   assign dist_in.slot  = s1_slot_ff;
   assign dist_in.key   = rd_entry.key;
   assign dist_in.off_x = rd_entry.off_x;
   assign dist_in.off_z = rd_entry.off_z;

   sfe_dist_unit u_dist (
      .clock  (clock),
      .reset  (reset),
      .clear  (start),
      .din    (dist_in),
      .cam_x  (cam_x_ff),
      .cam_z  (cam_z_ff),
      .extent (extent_ff),
      .busy   (dist_busy),
      .best   (best)
   );

   // ------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         cam_x_ff  <= '0;
         cam_z_ff  <= '0;
         extent_ff <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_CAMERA_X: begin
               cam_x_ff <= signed'(csr_wdata[POS_W-1:0]);
            end
            CSR_CAMERA_Z: begin
               cam_z_ff <= signed'(csr_wdata[POS_W-1:0]);
            end
            CSR_TILE_EXTENT: begin
               extent_ff <= csr_wdata[EXT_W-1:0];
            end
            default: begin
               // unused index, write dropped
            end
         endcase
      end
   end

   // ------------------------------------------------------------------
   // sequencer: idle, scan every slot, drain the pipeline, commit
   // ------------------------------------------------------------------
   assign last_addr = (addr_ff == SLOT_W'(SLOT_CAPACITY - 1));

   always_comb begin
      state_in  = state_ff;
      addr_in   = addr_ff;
      req_ready = 1'b0;
      issue     = 1'b0;
      start     = 1'b0;
      commit    = 1'b0;
      unique case (state_ff)
         SEQ_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               start    = 1'b1;
               addr_in  = '0;
               state_in = SEQ_SCAN;
            end
         end
         SEQ_SCAN: begin
            issue   = 1'b1;
            addr_in = addr_ff + SLOT_W'(1);
            if (last_addr) begin
               state_in = SEQ_DRAIN;
            end
         end
         SEQ_DRAIN: begin
            // wait for the last entry to leave the pipeline and the
            // previous response to be taken
            if (!s1_live_ff && !dist_busy && (!rsp_valid_ff || rsp_ready)) begin
               commit   = 1'b1;
               state_in = SEQ_IDLE;
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= SEQ_IDLE;
         addr_ff    <= '0;
         s1_live_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         addr_ff    <= addr_in;
         s1_live_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      s1_slot_ff <= addr_ff;
      if (start) begin
         req_ff <= req_data;
      end
   end

   // ------------------------------------------------------------------
   // key lookup: first valid entry with a matching key
   // ------------------------------------------------------------------
   assign key_match = (rd_entry.key == {req_ff.key_z, req_ff.key_x});

   always_comb begin
      hit_in       = hit_ff;
      found_in     = found_ff;
      found_cnt_in = found_cnt_ff;
      if (start) begin
         hit_in = 1'b0;
      end else if (s1_live_ff && rd_entry.valid && key_match && !hit_ff) begin
         hit_in       = 1'b1;
         found_in     = s1_slot_ff;
         found_cnt_in = rd_entry.updates;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      found_ff     <= found_in;
      found_cnt_ff <= found_cnt_in;
   end

   // ------------------------------------------------------------------
   // commit: table and pool updates plus the response
   // ------------------------------------------------------------------
   always_comb begin
      tbl_wr             = '0;
      tbl_wr.key         = {req_ff.key_z, req_ff.key_x};
      tbl_wr.off_x       = req_ff.offset_x;
      tbl_wr.off_z       = req_ff.offset_z;
      pool_ctl           = '0;
      pool_ctl.push_slot = found_ff;
      rsp_data_in        = rsp_data_ff;
      rsp_valid_in       = rsp_valid_ff && !rsp_ready;

      if (commit) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in               = '0;
         rsp_data_in.status        = STS_ABSENT;

         unique case (req_ff.action)
            ACT_REGISTER: begin
               if (hit_ff) begin
                  // present key: bump the saturating count, offset kept
                  tbl_wr.set_upd   = 1'b1;
                  tbl_wr.addr      = found_ff;
                  tbl_wr.updates   = (found_cnt_ff == UPD_MAX) ? found_cnt_ff
                                                               : found_cnt_ff + UPD_W'(1);
                  rsp_data_in.status    = STS_UPDATED;
                  rsp_data_in.slot      = RSP_SLOT_W'(found_ff);
                  rsp_data_in.upd_count = tbl_wr.updates;
               end else begin
                  rsp_data_in.status = STS_INSERTED;
                  priority if (pool_stat.free_count != '0) begin
                     pool_ctl.pop = 1'b1;
                     tbl_wr.addr  = pool_stat.top_slot;
                  end else if (pool_stat.next_fresh < CNT_W'(SLOT_CAPACITY)) begin
                     pool_ctl.take_fresh = 1'b1;
                     tbl_wr.addr         = pool_stat.next_fresh[SLOT_W-1:0];
                  end else if (best.any) begin
                     // table full: reuse the farthest slot
                     tbl_wr.addr                = best.slot;
                     rsp_data_in.status         = STS_EVICTED;
                     rsp_data_in.evicted        = 1'b1;
                     rsp_data_in.evicted_key_x  = signed'(best.key[KEY_W-1:0]);
                     rsp_data_in.evicted_key_z  = signed'(best.key[ENTRY_KEY_W-1:KEY_W]);
                  end else begin
                     tbl_wr.addr = '0;
                  end
                  tbl_wr.set_entry = 1'b1;
                  tbl_wr.set_upd   = 1'b1;
                  tbl_wr.updates   = '0;
                  rsp_data_in.slot = RSP_SLOT_W'(tbl_wr.addr);
               end
            end
            ACT_UNREGISTER: begin
               if (hit_ff) begin
                  tbl_wr.clr_valid      = 1'b1;
                  tbl_wr.addr           = found_ff;
                  pool_ctl.push         = 1'b1;
                  rsp_data_in.status    = STS_REMOVED;
                  rsp_data_in.slot      = RSP_SLOT_W'(found_ff);
                  rsp_data_in.upd_count = found_cnt_ff;
               end
            end
            default: begin
               // query, and the unused action code behaves as a query
               if (hit_ff) begin
                  rsp_data_in.status    = STS_PRESENT;
                  rsp_data_in.slot      = RSP_SLOT_W'(found_ff);
                  rsp_data_in.upd_count = found_cnt_ff;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the farthest-evict slot allocator: requests are
// predicted by a behavioral copy of the slot table, responses are checked in
// order, with directed, eviction, random and backpressure tests
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import sfe_pkg::*;

   localparam int CLK_HALF     = 4;
   localparam int RESET_CYCLES = 7;
   // one full table scan plus pipeline drain per request
   localparam int RSP_LATENCY  = SLOT_CAPACITY + 5;
   localparam int HOLD_CYCLES  = 3000;
   localparam int POOL_SIZE    = 300;

   // action codes not named in the package
   localparam logic [1:0] ACT_QUERY = 2'd2;
   localparam logic [1:0] ACT_SPARE = 2'd3;
   // unused register index, writes to it must be ignored
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;

   logic                   clock        = 1'b0;
   logic                   reset        = 1'b1;
   logic                   req_valid    = 1'b0;
   logic                   req_ready;
   req_type                req_data     = '0;
   logic                   rsp_valid;
   logic                   rsp_ready    = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index    = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata    = '0;

   // predicted slot table
   bit                      slot_used    [SLOT_CAPACITY];
   logic signed [KEY_W-1:0] slot_key_x   [SLOT_CAPACITY];
   logic signed [KEY_W-1:0] slot_key_z   [SLOT_CAPACITY];
   logic signed [POS_W-1:0] slot_off_x   [SLOT_CAPACITY];
   logic signed [POS_W-1:0] slot_off_z   [SLOT_CAPACITY];
   logic [UPD_W-1:0]        slot_updates [SLOT_CAPACITY];
   // freed slots, last in first out
   int                      free_list  [SLOT_CAPACITY];
   int                      free_depth = 0;
   int                      fresh_slot = 0;
   logic signed [POS_W-1:0] cam_x      = '0;
   logic signed [POS_W-1:0] cam_z      = '0;
   logic [EXT_W-1:0]        extent     = '0;

   // responses predicted at request acceptance, oldest first
   rsp_type pending_responses[$];
   int      error_count = 0;

   // idling controls, read by the sender task and the receiver process
   int   send_idle_pct = 0;
   int   stall_pct     = 0;
   // toggling hold_trigger starts one long receiver hold-off
   logic hold_trigger  = 1'b0;
   logic hold_ack      = 1'b0;
   int   hold_left     = 0;

   logic [2*KEY_W-1:0] key_pool [POOL_SIZE];

   slot_allocator_farthest_evict_unit u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #(CLK_HALF) clock = ~clock;

   // ---------------------------------------------------------------------------
   // prediction
   // ---------------------------------------------------------------------------

   // squared distance from camera to tile centre, in units of 2^-18
   // (differences doubled so that extent/2 stays exact)
   function automatic longint centre_dist_sq(int s);
      longint dx;
      longint dz;
      dx = 2 * longint'(slot_off_x[s]) + longint'(extent) - 2 * longint'(cam_x);
      dz = 2 * longint'(slot_off_z[s]) + longint'(extent) - 2 * longint'(cam_z);
      return dx * dx + dz * dz;
   endfunction

   // apply one request to the predicted table and return its response
   function automatic rsp_type table_apply(req_type r);
      rsp_type o;
      int      hit_slot;
      int      ns;
      longint  best;
      longint  d;
      bit      any;
      o        = '0;
      hit_slot = -1;
      ns       = 0;
      best     = 0;
      any      = 1'b0;
      for (int s = 0; s < SLOT_CAPACITY; s++) begin
         if (slot_used[s] && slot_key_x[s] == r.key_x && slot_key_z[s] == r.key_z
             && hit_slot < 0) begin
            hit_slot = s;
         end
      end
      if (r.action == ACT_REGISTER) begin
         if (hit_slot >= 0) begin
            // present key: count goes up, stored offset stays as it was
            if (slot_updates[hit_slot] != UPD_MAX) begin
               slot_updates[hit_slot]++;
            end
            o.status    = STS_UPDATED;
            o.slot      = RSP_SLOT_W'(hit_slot);
            o.upd_count = slot_updates[hit_slot];
         end else begin
            o.status = STS_INSERTED;
            if (free_depth != 0) begin
               free_depth--;
               ns = free_list[free_depth];
            end else if (fresh_slot < SLOT_CAPACITY) begin
               ns = fresh_slot;
               fresh_slot++;
            end else begin
               // full table: farthest centre goes, lowest slot on a tie
               for (int s = 0; s < SLOT_CAPACITY; s++) begin
                  if (slot_used[s]) begin
                     d = centre_dist_sq(s);
                     if (!any || d > best) begin
                        best = d;
                        ns   = s;
                        any  = 1'b1;
                     end
                  end
               end
               o.status        = STS_EVICTED;
               o.evicted       = 1'b1;
               o.evicted_key_x = slot_key_x[ns];
               o.evicted_key_z = slot_key_z[ns];
            end
            slot_used[ns]    = 1'b1;
            slot_key_x[ns]   = r.key_x;
            slot_key_z[ns]   = r.key_z;
            slot_off_x[ns]   = r.offset_x;
            slot_off_z[ns]   = r.offset_z;
            slot_updates[ns] = '0;
            o.slot           = RSP_SLOT_W'(ns);
         end
      end else if (hit_slot < 0) begin
         // absent key on unregister or query: no state change
         o.status = STS_ABSENT;
      end else if (r.action == ACT_UNREGISTER) begin
         o.status            = STS_REMOVED;
         o.slot              = RSP_SLOT_W'(hit_slot);
         o.upd_count         = slot_updates[hit_slot];
         slot_used[hit_slot] = 1'b0;
         if (free_depth < SLOT_CAPACITY) begin
            free_list[free_depth] = hit_slot;
            free_depth++;
         end
      end else begin
         // query, the spare action code behaves the same
         o.status    = STS_PRESENT;
         o.slot      = RSP_SLOT_W'(hit_slot);
         o.upd_count = slot_updates[hit_slot];
      end
      return o;
   endfunction

   // ---------------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------------

   function automatic req_type make_req(logic [1:0] act, int kx, int kz,
                                        int ox = 0, int oz = 0);
      req_type r;
      r.action   = act;
      r.key_x    = KEY_W'(kx);
      r.key_z    = KEY_W'(kz);
      r.offset_x = POS_W'(ox);
      r.offset_z = POS_W'(oz);
      return r;
   endfunction

   // offsets lean toward the extremes and repeated values to force ties
   function automatic logic signed [POS_W-1:0] pick_position();
      case ($urandom_range(7))
         0: return {1'b1, {(POS_W-1){1'b0}}};
         1: return {1'b0, {(POS_W-1){1'b1}}};
         2: return '0;
         3: return POS_W'(256);
         default: return POS_W'($urandom());
      endcase
   endfunction

   // mostly pool keys so that hits, removals and evictions keep happening,
   // the rest fully random keys and action codes
   function automatic req_type random_request();
      req_type            r;
      int                 sel;
      logic [2*KEY_W-1:0] key;
      sel = $urandom_range(99);
      key = key_pool[$urandom_range(POOL_SIZE-1)];
      if (sel < 50) begin
         r.action = ACT_REGISTER;
      end else if (sel < 65) begin
         r.action = ACT_UNREGISTER;
      end else if (sel < 80) begin
         r.action = ACT_QUERY;
      end else if (sel < 85) begin
         r.action = ACT_SPARE;
      end else begin
         r.action = 2'($urandom_range(3));
         key      = $urandom();
      end
      r.key_x    = key[2*KEY_W-1:KEY_W];
      r.key_z    = key[KEY_W-1:0];
      r.offset_x = pick_position();
      r.offset_z = pick_position();
      return r;
   endfunction

   // one request transaction; valid stays high on return so that a following
   // request can go out in the next cycle without a bubble
   task automatic send_request(input req_type r);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      pending_responses.push_back(table_apply(r));
   endtask

   // drop valid and wait until every predicted response has come back
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // back-to-back register writes, the spare index gets random data
   task automatic load_camera(input logic signed [POS_W-1:0] cx,
                              input logic signed [POS_W-1:0] cz,
                              input logic [EXT_W-1:0] ext);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_CAMERA_X;
      csr_wdata    <= cx;
      @(posedge clock);
      csr_index    <= CSR_CAMERA_Z;
      csr_wdata    <= cz;
      @(posedge clock);
      // the top bit lies above the extent field and is dropped
      csr_index    <= CSR_TILE_EXTENT;
      csr_wdata    <= {1'($urandom_range(1)), ext};
      @(posedge clock);
      csr_index    <= CSR_SPARE;
      csr_wdata    <= CSR_DATA_W'($urandom());
      @(posedge clock);
      csr_write_en <= 1'b0;
      cam_x  = cx;
      cam_z  = cz;
      extent = ext;
   endtask

   // ---------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------

   // key and offset extremes, every action, stack reuse order and absent keys
   task automatic test_directed();
      send_idle_pct = 0;
      stall_pct     = 0;
      load_camera('0, '0, '0);
      send_request(make_req(ACT_QUERY, 0, 0));                  // empty table
      send_request(make_req(ACT_UNREGISTER, -32768, 32767));
      send_request(make_req(ACT_REGISTER, -32768, -32768, -8388608, 8388607));
      send_request(make_req(ACT_REGISTER, 32767, 32767, 8388607, -8388608));
      send_request(make_req(ACT_REGISTER, 0, 0, 0, 0));
      // re-register keeps the first offset
      send_request(make_req(ACT_REGISTER, -32768, -32768, 5, 5));
      send_request(make_req(ACT_REGISTER, -32768, -32768, 0, 0));
      send_request(make_req(ACT_QUERY, -32768, -32768));
      send_request(make_req(ACT_SPARE, 32767, 32767));          // spare code queries
      send_request(make_req(ACT_SPARE, 1, 2));
      send_request(make_req(ACT_UNREGISTER, 32767, 32767));
      send_request(make_req(ACT_UNREGISTER, 32767, 32767));     // already gone
      send_request(make_req(ACT_QUERY, 32767, 32767));
      send_request(make_req(ACT_REGISTER, 1, -1, 256, -256));   // reuses freed slot
      send_request(make_req(ACT_UNREGISTER, -32768, -32768));
      send_request(make_req(ACT_UNREGISTER, 0, 0));
      // freed slots come back last in, first out
      send_request(make_req(ACT_REGISTER, -1, 1, 1, 1));
      send_request(make_req(ACT_REGISTER, 32767, -32768, -1, -1));
      send_request(make_req(ACT_REGISTER, 21845, -21846, 0, 0)); // never-used slot
      send_request(make_req(ACT_QUERY, 21845, -21846));
      wait_idle();
   endtask

   // stream of new keys: fills the table, then every insert evicts
   task automatic test_eviction(input logic signed [POS_W-1:0] cx,
                                input logic signed [POS_W-1:0] cz,
                                input logic [EXT_W-1:0] ext,
                                input int idle_send, input int idle_recv,
                                input int items);
      logic [2*KEY_W-1:0] key;
      load_camera(cx, cz, ext);
      send_idle_pct = idle_send;
      stall_pct     = idle_recv;
      repeat (items) begin
         key = $urandom();
         send_request(make_req(ACT_REGISTER, key[2*KEY_W-1:KEY_W], key[KEY_W-1:0],
                               pick_position(), pick_position()));
      end
      wait_idle();
   endtask

   // mixed traffic over the key pool under one camera setting
   task automatic test_random_mix(input int idle_send, input int idle_recv,
                                  input int items);
      load_camera(POS_W'($urandom()), POS_W'($urandom()), EXT_W'($urandom()));
      send_idle_pct = idle_send;
      stall_pct     = idle_recv;
      repeat (items) send_request(random_request());
      wait_idle();
   endtask

   // receiver holds off for a long stretch while requests keep coming, so
   // the output register and the scan both fill and req_ready drops
   task automatic test_backpressure(input int items);
      send_idle_pct = 0;
      stall_pct     = 0;
      hold_trigger <= ~hold_trigger;
      repeat (items) send_request(random_request());
      wait_idle();
   endtask

   // ---------------------------------------------------------------------------
   // response side
   // ---------------------------------------------------------------------------

   // random stalls, plus one counted hold-off per trigger toggle
   always @(posedge clock) begin
      if (hold_trigger != hold_ack) begin
         hold_ack  <= hold_trigger;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // every response transaction against the oldest prediction
   always @(posedge clock) begin : check_responses
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_responses.size() == 0) begin
            error_count++;
            $display("%0t: response with none expected, actual %p", $realtime, rsp_data);
         end else begin
            want = pending_responses.pop_front();
            if (rsp_data.status !== want.status) begin
               error_count++;
               $display("%0t: status mismatch, expected %0d, actual %0d",
                        $realtime, want.status, rsp_data.status);
            end
            if (rsp_data.slot !== want.slot) begin
               error_count++;
               $display("%0t: slot mismatch, expected %0d, actual %0d",
                        $realtime, want.slot, rsp_data.slot);
            end
            if (rsp_data.evicted !== want.evicted) begin
               error_count++;
               $display("%0t: evicted mismatch, expected %0d, actual %0d",
                        $realtime, want.evicted, rsp_data.evicted);
            end
            if (rsp_data.evicted_key_x !== want.evicted_key_x) begin
               error_count++;
               $display("%0t: evicted_key_x mismatch, expected %0d, actual %0d",
                        $realtime, want.evicted_key_x, rsp_data.evicted_key_x);
            end
            if (rsp_data.evicted_key_z !== want.evicted_key_z) begin
               error_count++;
               $display("%0t: evicted_key_z mismatch, expected %0d, actual %0d",
                        $realtime, want.evicted_key_z, rsp_data.evicted_key_z);
            end
            if (rsp_data.upd_count !== want.upd_count) begin
               error_count++;
               $display("%0t: upd_count mismatch, expected %0d, actual %0d",
                        $realtime, want.upd_count, rsp_data.upd_count);
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // test sequence
   // ---------------------------------------------------------------------------

   initial begin
      for (int i = 0; i < POOL_SIZE; i++) begin
         key_pool[i] = $urandom();
      end
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      // camera at opposite corners, widest and zero extent
      test_eviction({1'b0, {(POS_W-1){1'b1}}}, {1'b1, {(POS_W-1){1'b0}}}, '1,
                    47, 0, 300);
      test_eviction({1'b1, {(POS_W-1){1'b0}}}, {1'b0, {(POS_W-1){1'b1}}}, '0,
                    0, 47, 300);
      test_random_mix(0, 0, 250);
      test_random_mix(47, 0, 250);
      test_random_mix(0, 47, 250);
      test_random_mix(8, 8, 250);
      test_backpressure(40);

      // let any stray response show up
      repeat (RSP_LATENCY) @(posedge clock);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // watchdog, well beyond the slowest legal run
   initial begin
      #40ms;
      $display("tb: failure");
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/sfe_pkg.sv
hw/rtl/sfe_table.sv
hw/rtl/sfe_slot_pool.sv
hw/rtl/sfe_dist_unit.sv
hw/rtl/slot_allocator_farthest_evict_unit.sv
tb/testbench.sv
